// ===== rtl/assert_macros.svh =====
// Assertion macros used by the reply queue, the only RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock, off in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/arp_pkg.sv =====
// Shared types and constants of the ARP request responder.
`default_nettype none

package arp_pkg;

    localparam int unsigned MAC_W       = 48;
    localparam int unsigned IP_W        = 32;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_STATION_MAC = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATION_IP  = 1'b1;

    localparam logic [MAC_W-1:0] STATION_MAC_RESET = 48'h5254_0012_3456;
    localparam logic [IP_W-1:0]  STATION_IP_RESET  = 32'h0A00_020F;

    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
    } t_reply;

    typedef struct packed {
        logic   valid;
        t_reply entry;
    } t_beat_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0: b = ip[31:24];
            2'd1: b = ip[23:16];
            2'd2: b = ip[15:8];
            2'd3: b = ip[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/arp_front.sv =====
// Receive parser: counts frame bytes, checks the ARP request, captures the requester.
`default_nettype none

module arp_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rx_valid,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_rx_last,
    output logic                           o_rx_stall,
    input  wire logic [arp_pkg::IP_W-1:0]  i_station_ip,
    input  wire arp_pkg::t_queue_status    i_queue_status,
    output arp_pkg::t_beat_req             o_push
);

    localparam logic [5:0] POS_MAX   = 6'd63;
    localparam logic [5:0] HDR_START = 6'd14;
    localparam logic [5:0] MAC_START = 6'd22;
    localparam logic [5:0] IP_START  = 6'd28;
    localparam logic [5:0] IP_END    = 6'd32;
    localparam logic [5:0] TIP_START = 6'd38;
    localparam logic [5:0] TIP_END   = 6'd42;
    localparam logic [5:0] MIN_LAST  = 6'd41;

    logic [5:0]                 r_pos, n_pos;
    logic                       r_match, n_match;
    logic [arp_pkg::MAC_W-1:0]  r_req_mac, n_req_mac;
    logic [arp_pkg::IP_W-1:0]   r_req_ip, n_req_ip;
    logic                       accept;
    logic                       byte_ok;
    logic [2:0]                 hdr_idx;
    logic [1:0]                 tip_idx;
    logic [7:0]                 hdr_exp;

    function automatic logic [7:0] rx_hdr_byte(input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0: b = 8'h00;
            3'd1: b = 8'h01;
            3'd2: b = 8'h08;
            3'd3: b = 8'h00;
            3'd4: b = 8'h06;
            3'd5: b = 8'h04;
            3'd6: b = 8'h00;
            3'd7: b = 8'h01;
        endcase
        return b;
    endfunction

    assign o_rx_stall = i_queue_status.full;
    assign accept     = i_rx_valid && !o_rx_stall;
    assign hdr_idx    = 3'(r_pos - HDR_START);
    assign tip_idx    = 2'(r_pos - TIP_START);
    assign hdr_exp    = rx_hdr_byte(hdr_idx);

    always_comb begin
        byte_ok   = 1'b1;
        n_req_mac = r_req_mac;
        n_req_ip  = r_req_ip;
        priority if (r_pos >= HDR_START && r_pos < MAC_START) begin
            byte_ok = (i_rx_byte == hdr_exp);
        end else if (r_pos >= MAC_START && r_pos < IP_START) begin
            n_req_mac = {r_req_mac[arp_pkg::MAC_W-9:0], i_rx_byte};
        end else if (r_pos >= IP_START && r_pos < IP_END) begin
            n_req_ip = {r_req_ip[arp_pkg::IP_W-9:0], i_rx_byte};
        end else if (r_pos >= TIP_START && r_pos < TIP_END) begin
            byte_ok = (i_rx_byte == arp_pkg::ip_byte(i_station_ip, tip_idx));
        end else begin
            byte_ok = 1'b1;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_match = r_match;
        if (accept) begin
            if (i_rx_last) begin
                n_pos   = 6'd0;
                n_match = 1'b1;
            end else begin
                n_match = r_match && byte_ok;
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 6'd1;
                end
            end
        end
    end

    always_comb begin
        o_push.valid     = accept && i_rx_last && r_match && byte_ok && (r_pos >= MIN_LAST);
        o_push.entry.mac = n_req_mac;
        o_push.entry.ip  = n_req_ip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 6'd0;
            r_match   <= 1'b1;
            r_req_mac <= '0;
            r_req_ip  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_match <= n_match;
            if (accept) begin
                r_req_mac <= n_req_mac;
                r_req_ip  <= n_req_ip;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/arp_queue.sv =====
// Reply queue between the receive parser and the reply generator.
`default_nettype none
`include "assert_macros.svh"

module arp_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire arp_pkg::t_beat_req     i_push,
    input  wire logic                   i_pop,
    output arp_pkg::t_queue_status      o_status,
    output arp_pkg::t_beat_req          o_head
);

    localparam int unsigned DEPTH = arp_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    arp_pkg::t_reply    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push;
    logic               pop;

    assign push = i_push.valid;
    assign pop  = i_pop && (r_count != '0);

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head.valid   = (r_count != '0);
    assign o_head.entry   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, r_count > CNT_W'(DEPTH), "queue count overflow")
    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, push && o_status.full, "push into full queue")
    `ASSERT_CLK(a_drain_to_empty, i_clk, i_rst_n, (pop && !push && r_count == CNT_W'(1)) |=> o_status.empty, "queue not empty after last pop")

endmodule

`default_nettype wire

// ===== rtl/arp_back.sv =====
// Reply generator: serializes one queued ARP reply per burst into an output register.
`default_nettype none

module arp_back #(
    parameter int unsigned REPLY_BYTES = 60
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire arp_pkg::t_beat_req        i_head,
    output logic                           o_pop,
    input  wire logic [arp_pkg::MAC_W-1:0] i_station_mac,
    input  wire logic [arp_pkg::IP_W-1:0]  i_station_ip,
    output logic                           o_tx_valid,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_tx_last,
    input  wire logic                      i_tx_stall
);

    localparam int unsigned POS_W = $clog2(REPLY_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPLY_BYTES - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_tx_valid, n_tx_valid;
    logic [7:0]       r_tx_byte;
    logic             r_tx_last;
    logic             load;
    logic             at_last;
    logic [7:0]       next_byte;

    function automatic logic [7:0] tx_hdr_byte(input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0: b = 8'h00;
            3'd1: b = 8'h01;
            3'd2: b = 8'h08;
            3'd3: b = 8'h00;
            3'd4: b = 8'h06;
            3'd5: b = 8'h04;
            3'd6: b = 8'h00;
            3'd7: b = 8'h02;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] reply_byte(
        input logic [5:0]                p,
        input arp_pkg::t_reply           req,
        input logic [arp_pkg::MAC_W-1:0] smac,
        input logic [arp_pkg::IP_W-1:0]  sip
    );
        logic [7:0] b;
        priority if (p < 6'd6) begin
            b = arp_pkg::mac_byte(req.mac, p[2:0]);
        end else if (p < 6'd12) begin
            b = arp_pkg::mac_byte(smac, 3'(p - 6'd6));
        end else if (p == 6'd12) begin
            b = 8'h08;
        end else if (p == 6'd13) begin
            b = 8'h06;
        end else if (p < 6'd22) begin
            b = tx_hdr_byte(3'(p - 6'd14));
        end else if (p < 6'd28) begin
            b = arp_pkg::mac_byte(smac, 3'(p - 6'd22));
        end else if (p < 6'd32) begin
            b = arp_pkg::ip_byte(sip, 2'(p - 6'd28));
        end else if (p < 6'd38) begin
            b = arp_pkg::mac_byte(req.mac, 3'(p - 6'd32));
        end else if (p < 6'd42) begin
            b = arp_pkg::ip_byte(req.ip, 2'(p - 6'd38));
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

    assign load      = i_head.valid && (!r_tx_valid || !i_tx_stall);
    assign at_last   = (r_pos == POS_LAST);
    assign next_byte = reply_byte(6'(r_pos), i_head.entry, i_station_mac, i_station_ip);
    assign o_pop     = load && at_last;

    always_comb begin
        n_pos      = r_pos;
        n_tx_valid = r_tx_valid;
        if (load) begin
            n_tx_valid = 1'b1;
            n_pos      = at_last ? '0 : r_pos + POS_W'(1);
        end else if (!i_tx_stall) begin
            n_tx_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_byte <= next_byte;
            r_tx_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_tx_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_tx_valid <= n_tx_valid;
        end
    end

    assign o_tx_valid = r_tx_valid;
    assign o_tx_byte  = r_tx_byte;
    assign o_tx_last  = r_tx_last;

endmodule

`default_nettype wire

// ===== rtl/arp_request_responder.sv =====
// Top level of the ARP request responder: station registers, parser, queue, generator.
// Input: one received byte per cycle; o_rx_stall rises only while two replies are queued.
// Reply path: the accepted last byte is written into the queue, then the idle generator loads the first beat.
// Output: the generator sends REPLY_BYTES beats per reply, one beat per cycle while i_tx_stall is low.
// Reset: synchronous active-low; clears parser, queue and output valid, reloads station regs.
`default_nettype none

module arp_request_responder #(
    parameter int unsigned REPLY_BYTES = 60
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [arp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [arp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_rx_valid,
    input  wire logic [7:0]                          i_rx_byte,
    input  wire logic                                i_rx_last,
    output logic                                     o_rx_stall,
    output logic                                     o_tx_valid,
    output logic [7:0]                               o_tx_byte,
    output logic                                     o_tx_last,
    input  wire logic                                i_tx_stall
);

    logic [arp_pkg::MAC_W-1:0] r_station_mac;
    logic [arp_pkg::IP_W-1:0]  r_station_ip;
    arp_pkg::t_beat_req        push;
    arp_pkg::t_beat_req        head;
    arp_pkg::t_queue_status    queue_status;
    logic                      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_mac <= arp_pkg::STATION_MAC_RESET;
            r_station_ip  <= arp_pkg::STATION_IP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                arp_pkg::CFG_STATION_MAC: r_station_mac <= i_cfg_data[arp_pkg::MAC_W-1:0];
                arp_pkg::CFG_STATION_IP:  r_station_ip  <= i_cfg_data[arp_pkg::IP_W-1:0];
            endcase
        end
    end

    arp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .i_rx_byte      (i_rx_byte),
        .i_rx_last      (i_rx_last),
        .o_rx_stall     (o_rx_stall),
        .i_station_ip   (r_station_ip),
        .i_queue_status (queue_status),
        .o_push         (push)
    );

    arp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (queue_status),
        .o_head   (head)
    );

    arp_back #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_station_mac (r_station_mac),
        .i_station_ip  (r_station_ip),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_tx_last     (o_tx_last),
        .i_tx_stall    (i_tx_stall)
    );

endmodule

`default_nettype wire

// ===== dv/arp_request_responder_tb.sv =====
// Self-checking testbench for the ARP request responder: directed frames, random frames, checks.
module arp_request_responder_tb;

    localparam int unsigned REPLY_BYTES     = 60;
    localparam int          NO_CORRUPT      = -1;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          END_WAIT_CYCLES = 20000;
    localparam int          PHASE_BYTES     = 15;
    localparam int          PRESSURE_TAIL   = 8;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [63:0] ARP_REQUEST_HDR = 64'h0001_0800_0604_0001;
    localparam logic [63:0] ARP_REPLY_HDR   = 64'h0001_0800_0604_0002;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct {
        int          len;
        int          bad_pos;
        logic [7:0]  bad_mask;
        t_fill       fill;
        int          replies;
    } t_frame_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tx_beat;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [arp_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [arp_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                            i_rx_valid  = 1'b0;
    logic [7:0]                      i_rx_byte   = 8'h00;
    logic                            i_rx_last   = 1'b0;
    logic                            i_tx_stall  = 1'b0;
    logic                            o_rx_stall;
    logic                            o_tx_valid;
    logic [7:0]                      o_tx_byte;
    logic                            o_tx_last;

    // predictor state
    logic [47:0] own_mac = arp_pkg::STATION_MAC_RESET;
    logic [31:0] own_ip  = arp_pkg::STATION_IP_RESET;
    logic [5:0]  rx_pos  = 6'd0;
    logic        hdr_ok  = 1'b1;
    logic [47:0] req_mac = 48'h0;
    logic [31:0] req_ip  = 32'h0;

    t_tx_beat    reply_beats_q[$];
    logic [7:0]  frame_bytes[$];
    int          mismatch_count = 0;
    int          tx_beats_seen  = 0;
    bit          rx_quiet       = 1'b0;
    bit          tx_quiet       = 1'b0;
    bit          hold_off_req   = 1'b0;

    t_frame_row directed_rows[6] = '{
        '{42, NO_CORRUPT, 8'h00, FILL_ZERO,   1},
        '{64, NO_CORRUPT, 8'h00, FILL_ONES,   1},
        '{1,  NO_CORRUPT, 8'h00, FILL_ONES,   0},
        '{42, 12,         8'hFF, FILL_RANDOM, 1},
        '{42, 17,         8'h01, FILL_RANDOM, 0},
        '{42, 41,         8'h01, FILL_ONES,   0}
    };

    arp_request_responder #(
        .REPLY_BYTES (REPLY_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .i_rx_last   (i_rx_last),
        .o_rx_stall  (o_rx_stall),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_tx_last   (o_tx_last),
        .i_tx_stall  (i_tx_stall)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] fill_byte(input t_fill fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] reply_byte_at(input int p);
        if (p < 6)   return req_mac[47-8*p -: 8];
        if (p < 12)  return own_mac[47-8*(p-6) -: 8];
        if (p == 12) return 8'h08;
        if (p == 13) return 8'h06;
        if (p < 22)  return ARP_REPLY_HDR[63-8*(p-14) -: 8];
        if (p < 28)  return own_mac[47-8*(p-22) -: 8];
        if (p < 32)  return own_ip[31-8*(p-28) -: 8];
        if (p < 38)  return req_mac[47-8*(p-32) -: 8];
        if (p < 42)  return req_ip[31-8*(p-38) -: 8];
        return 8'h00;
    endfunction

    task automatic parse_rx_beat(input logic [7:0] b, input logic last);
        int p;
        t_tx_beat beat;
        p = int'(rx_pos);
        if (p >= 14 && p < 22) begin
            if (b != ARP_REQUEST_HDR[63-8*(p-14) -: 8]) hdr_ok = 1'b0;
        end else if (p >= 22 && p < 28) begin
            req_mac = {req_mac[39:0], b};
        end else if (p >= 28 && p < 32) begin
            req_ip = {req_ip[23:0], b};
        end else if (p >= 38 && p < 42) begin
            if (b != own_ip[31-8*(p-38) -: 8]) hdr_ok = 1'b0;
        end
        if (last) begin
            if (hdr_ok && p >= 41) begin
                for (int k = 0; k < REPLY_BYTES; k++) begin
                    beat.data = reply_byte_at(k);
                    beat.last = (k == REPLY_BYTES - 1);
                    reply_beats_q.push_back(beat);
                end
            end
            rx_pos = 6'd0;
            hdr_ok = 1'b1;
        end else if (rx_pos != 6'd63) begin
            rx_pos = rx_pos + 6'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_rx_valid && !o_rx_stall) parse_rx_beat(i_rx_byte, i_rx_last);
    end

    always @(posedge i_clk) begin
        t_tx_beat want;
        if (i_rst_n && o_tx_valid && !i_tx_stall) begin
            tx_beats_seen++;
            if (reply_beats_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected reply beat: tx_byte=%02h tx_last=%0b",
                             o_tx_byte, o_tx_last);
            end else begin
                want = reply_beats_q.pop_front();
                if (o_tx_byte !== want.data || o_tx_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"reply beat mismatch: tx_byte exp %02h got %02h, ",
                                  "tx_last exp %0b got %0b"},
                                 want.data, o_tx_byte, want.last, o_tx_last);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n = HOLD_OFF_CYCLES;
            end else begin
                n = pick_gap(tx_quiet);
            end
            if (n > 0) begin
                i_tx_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_tx_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(rx_quiet);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        i_rx_last  <= last;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
    endtask

    task automatic send_frame(input bit busy);
        rx_quiet = busy || ($urandom_range(0, 4) == 0);
        tx_quiet = ($urandom_range(0, 4) == 0);
        foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    task automatic build_request(input int len, input t_fill fill, input logic [31:0] dst_ip,
                                 input int bad_pos, input logic [7:0] bad_mask);
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [7:0]  b;
        for (int k = 0; k < 6; k++) src_mac = {src_mac[39:0], fill_byte(fill)};
        for (int k = 0; k < 4; k++) src_ip = {src_ip[23:0], fill_byte(fill)};
        frame_bytes.delete();
        for (int k = 0; k < len; k++) begin
            if (k < 6)        b = fill_byte(fill);
            else if (k < 12)  b = src_mac[47-8*(k-6) -: 8];
            else if (k == 12) b = 8'h08;
            else if (k == 13) b = 8'h06;
            else if (k < 22)  b = ARP_REQUEST_HDR[63-8*(k-14) -: 8];
            else if (k < 28)  b = src_mac[47-8*(k-22) -: 8];
            else if (k < 32)  b = src_ip[31-8*(k-28) -: 8];
            else if (k < 38)  b = fill_byte(fill);
            else if (k < 42)  b = dst_ip[31-8*(k-38) -: 8];
            else              b = fill_byte(fill);
            if (k == bad_pos) b = b ^ bad_mask;
            frame_bytes.push_back(b);
        end
    endtask

    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (reply_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_station_reg(input logic [arp_pkg::CFG_INDEX_W-1:0] idx,
                                     input logic [arp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == arp_pkg::CFG_STATION_MAC) own_mac = data[47:0];
        else if (idx == arp_pkg::CFG_STATION_IP) own_ip = data[31:0];
        @(posedge i_clk);
    endtask

    initial begin
        int          seen_before;
        int          phase_bytes;
        int          pick;
        int          len;
        logic [47:0] mac_val;
        logic [31:0] ip_val;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            seen_before = tx_beats_seen;
            build_request(directed_rows[r].len, directed_rows[r].fill, own_ip,
                          directed_rows[r].bad_pos, directed_rows[r].bad_mask);
            send_frame(1'b0);
            wait_idle();
            if (tx_beats_seen - seen_before != directed_rows[r].replies * REPLY_BYTES) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("directed frame %0d: reply beats exp %0d got %0d", r,
                             directed_rows[r].replies * REPLY_BYTES,
                             tx_beats_seen - seen_before);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    mac_val = 48'h0;
                    ip_val  = 32'h0;
                end
                1: begin
                    mac_val = 48'hFFFF_FFFF_FFFF;
                    ip_val  = 32'hFFFF_FFFF;
                end
                default: begin
                    mac_val = 48'({$urandom, $urandom});
                    ip_val  = $urandom;
                end
            endcase
            write_station_reg(arp_pkg::CFG_STATION_MAC, mac_val);
            // upper data bits are outside the register and must be dropped
            write_station_reg(arp_pkg::CFG_STATION_IP, {16'($urandom), ip_val});

            phase_bytes = 0;
            if (ph == 1) begin
                hold_off_req = 1'b1;
                wait (hold_off_req == 1'b0);
                repeat (2) begin
                    build_request(42, FILL_RANDOM, own_ip, NO_CORRUPT, 8'h00);
                    phase_bytes += frame_bytes.size();
                    send_frame(1'b1);
                end
                build_request(PRESSURE_TAIL, FILL_RANDOM, own_ip, NO_CORRUPT, 8'h00);
                phase_bytes += frame_bytes.size();
                send_frame(1'b1);
                wait_idle();
            end

            while (phase_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(49, 80)
                                                   : $urandom_range(42, 48);
                if (pick < 55) begin
                    build_request(len, t_fill'($urandom_range(0, 3) == 0 ?
                                  $urandom_range(1, 2) : 0), own_ip, NO_CORRUPT, 8'h00);
                end else if (pick < 65) begin
                    build_request(len, FILL_RANDOM, $urandom, NO_CORRUPT, 8'h00);
                end else if (pick < 75) begin
                    build_request(len, FILL_RANDOM, own_ip, $urandom_range(14, 21),
                                  8'($urandom_range(1, 255)));
                end else if (pick < 88) begin
                    build_request($urandom_range(1, 41), FILL_RANDOM, own_ip, NO_CORRUPT, 8'h00);
                end else begin
                    build_request(len, FILL_RANDOM, own_ip, NO_CORRUPT, 8'h00);
                    foreach (frame_bytes[k]) frame_bytes[k] = 8'($urandom_range(0, 255));
                end
                phase_bytes += frame_bytes.size();
                send_frame(1'b0);
            end
        end

        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < END_WAIT_CYCLES && reply_beats_q.size() != 0; n++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && reply_beats_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
